[hdl/dggc_pkg.sv]
// shared types and constants for the dynamic greedy graph colouring block
`timescale 1ns / 1ps

package dggc_pkg;

  localparam int unsigned VTX_W   = 6;
  localparam int unsigned COLOR_W = 7;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CHUNK_W = 3;
  localparam int unsigned CHUNK_N = 1 << CHUNK_W;
  localparam int unsigned KCNT_W  = COLOR_W - CHUNK_W;

  localparam logic [CNT_W-1:0]  COUNT_RESET      = 7'd64;
  localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_RANGE     = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NO_COLOR  = 2'd2;
  localparam logic              KIND_INSERT      = 1'b1;
  localparam int unsigned       REG_VERTEX_COUNT = 0;

  typedef struct packed {
    logic             kind;
    logic [VTX_W-1:0] vertex_a;
    logic [VTX_W-1:0] vertex_b;
  } item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color_a;
    logic [COLOR_W-1:0] color_b;
    logic               recolored;
    logic [STAT_W-1:0]  status;
  } result_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_WR_A,
    S_RD_B,
    S_WR_B,
    S_CAP_CA,
    S_CAP_CB,
    S_SCAN,
    S_DRAIN,
    S_SEARCH,
    S_FINISH
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_RD_A,
    CMD_WR_A,
    CMD_RD_B,
    CMD_WR_B,
    CMD_CAP_CA,
    CMD_CAP_CB,
    CMD_SCAN,
    CMD_DRAIN,
    CMD_SEARCH
  } cmd_e;

  typedef struct packed {
    logic cnt_last;
    logic out_of_range;
    logic conflict;
    logic search_found;
    logic search_none;
  } dp_status_t;

endpackage

[hdl/dggc_ram.sv]
// generic simple dual-port ram with registered read data
`timescale 1ns / 1ps

module dggc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/dggc_ctrl.sv]
// sequencing state machine for the colouring block
`timescale 1ns / 1ps

module dggc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_free_i,
  output logic                out_push_o,
  input  dggc_pkg::dp_status_t status_i,
  output dggc_pkg::cmd_e      cmd_o
);

  dggc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dggc_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = dggc_pkg::CMD_NONE;
    in_ready_o = 1'b0;
    out_push_o = 1'b0;
    case (state_q)
      dggc_pkg::S_CLEAR: begin
        cmd_o = dggc_pkg::CMD_CLEAR;
        if (status_i.cnt_last) begin
          state_d = dggc_pkg::S_IDLE;
        end
      end
      dggc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = dggc_pkg::CMD_LOAD;
          state_d = dggc_pkg::S_CHECK;
        end
      end
      dggc_pkg::S_CHECK: begin
        cmd_o   = dggc_pkg::CMD_RD_A;
        state_d = status_i.out_of_range ? dggc_pkg::S_FINISH : dggc_pkg::S_WR_A;
      end
      dggc_pkg::S_WR_A: begin
        cmd_o   = dggc_pkg::CMD_WR_A;
        state_d = dggc_pkg::S_RD_B;
      end
      dggc_pkg::S_RD_B: begin
        cmd_o   = dggc_pkg::CMD_RD_B;
        state_d = dggc_pkg::S_WR_B;
      end
      dggc_pkg::S_WR_B: begin
        cmd_o   = dggc_pkg::CMD_WR_B;
        state_d = dggc_pkg::S_CAP_CA;
      end
      dggc_pkg::S_CAP_CA: begin
        cmd_o   = dggc_pkg::CMD_CAP_CA;
        state_d = dggc_pkg::S_CAP_CB;
      end
      dggc_pkg::S_CAP_CB: begin
        cmd_o   = dggc_pkg::CMD_CAP_CB;
        state_d = status_i.conflict ? dggc_pkg::S_SCAN : dggc_pkg::S_FINISH;
      end
      dggc_pkg::S_SCAN: begin
        cmd_o = dggc_pkg::CMD_SCAN;
        if (status_i.cnt_last) begin
          state_d = dggc_pkg::S_DRAIN;
        end
      end
      dggc_pkg::S_DRAIN: begin
        cmd_o   = dggc_pkg::CMD_DRAIN;
        state_d = dggc_pkg::S_SEARCH;
      end
      dggc_pkg::S_SEARCH: begin
        cmd_o = dggc_pkg::CMD_SEARCH;
        if (status_i.search_found || status_i.search_none) begin
          state_d = dggc_pkg::S_FINISH;
        end
      end
      dggc_pkg::S_FINISH: begin
        if (out_free_i) begin
          out_push_o = 1'b1;
          state_d    = dggc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dggc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[hdl/dggc_datapath.sv]
// adjacency and colour stores, neighbour scan and free colour search
`timescale 1ns / 1ps

module dggc_datapath #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dggc_pkg::cmd_e                    cmd_i,
  input  dggc_pkg::item_t                   item_i,
  input  logic [dggc_pkg::CNT_W-1:0]        vertex_count_i,
  output dggc_pkg::dp_status_t              status_o,
  output dggc_pkg::result_t                 result_o
);

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam logic [dggc_pkg::CNT_W-1:0] LIM_MAX =
    (MAX_VERTICES > 127) ? 7'd127 : dggc_pkg::CNT_W'(MAX_VERTICES);
  localparam logic [VW-1:0] CNT_LAST = VW'(MAX_VERTICES - 1);
  localparam int unsigned USED_N = 1 << dggc_pkg::COLOR_W;

  dggc_pkg::item_t              item_q;
  logic [dggc_pkg::CNT_W-1:0]   limit_q;
  logic [dggc_pkg::COLOR_W-1:0] color_a_q, color_b_q;
  logic                         recolored_q;
  logic [dggc_pkg::STAT_W-1:0]  status_q;
  logic [MAX_VERTICES-1:0]      row_q;
  logic [VW-1:0]                cnt_q;
  logic [dggc_pkg::KCNT_W-1:0]  k_q;
  logic                         hit_q;
  logic [USED_N-1:0]            used_q;

  logic [VW-1:0]                a_idx, b_idx, row_bit;
  logic [dggc_pkg::CNT_W-1:0]   lim;
  logic                         oor;
  logic                         adj_we, col_we;
  logic [VW-1:0]                adj_waddr, adj_raddr, col_waddr, col_raddr;
  logic [MAX_VERTICES-1:0]      adj_wdata, adj_rdata, row_mod;
  logic [dggc_pkg::COLOR_W-1:0] col_wdata, col_rdata;
  logic                         found, none;
  logic [dggc_pkg::COLOR_W-1:0] found_color;

  assign a_idx = VW'(item_q.vertex_a);
  assign b_idx = VW'(item_q.vertex_b);

  // effective vertex count saturates at the store size
  assign lim = (vertex_count_i > LIM_MAX) ? LIM_MAX : vertex_count_i;
  assign oor = ({1'b0, item_i.vertex_a} >= lim) || ({1'b0, item_i.vertex_b} >= lim);

  // set or clear one edge bit in the row just read
  always_comb begin
    row_bit          = (cmd_i == dggc_pkg::CMD_WR_A) ? b_idx : a_idx;
    row_mod          = adj_rdata;
    row_mod[row_bit] = item_q.kind;
  end

  // lowest free colour in the current chunk of eight
  always_comb begin
    logic [dggc_pkg::COLOR_W-1:0] c;
    found       = 1'b0;
    found_color = '0;
    for (int j = dggc_pkg::CHUNK_N - 1; j >= 0; j--) begin
      c = {k_q, dggc_pkg::CHUNK_W'(j)};
      if ((c != '0) && (c <= limit_q) && !used_q[c]) begin
        found       = 1'b1;
        found_color = c;
      end
    end
    none = !found && ({k_q, {dggc_pkg::CHUNK_W{1'b1}}} >= limit_q);
  end

  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = a_idx;
    adj_wdata = row_mod;
    adj_raddr = a_idx;
    col_we    = 1'b0;
    col_waddr = b_idx;
    col_wdata = found_color;
    col_raddr = a_idx;
    case (cmd_i)
      dggc_pkg::CMD_CLEAR: begin
        adj_we    = 1'b1;
        adj_waddr = cnt_q;
        adj_wdata = '0;
        col_we    = 1'b1;
        col_waddr = cnt_q;
        col_wdata = '0;
      end
      dggc_pkg::CMD_WR_A: begin
        adj_we = 1'b1;
      end
      dggc_pkg::CMD_RD_B: begin
        adj_raddr = b_idx;
      end
      dggc_pkg::CMD_WR_B: begin
        adj_we    = 1'b1;
        adj_waddr = b_idx;
      end
      dggc_pkg::CMD_CAP_CA: begin
        col_raddr = b_idx;
      end
      dggc_pkg::CMD_SCAN: begin
        col_raddr = cnt_q;
      end
      dggc_pkg::CMD_SEARCH: begin
        col_we = found;
      end
      default: begin
      end
    endcase
  end

  dggc_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  dggc_ram #(
    .WIDTH (dggc_pkg::COLOR_W),
    .DEPTH (MAX_VERTICES)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (col_waddr),
    .wdata_i (col_wdata),
    .raddr_i (col_raddr),
    .rdata_o (col_rdata)
  );

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      k_q   <= '0;
      hit_q <= 1'b0;
    end else begin
      case (cmd_i)
        dggc_pkg::CMD_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
        end
        dggc_pkg::CMD_CAP_CB: begin
          cnt_q <= '0;
          hit_q <= 1'b0;
        end
        dggc_pkg::CMD_SCAN: begin
          cnt_q <= cnt_q + 1'b1;
          hit_q <= row_q[cnt_q];
        end
        dggc_pkg::CMD_DRAIN: begin
          hit_q <= 1'b0;
          k_q   <= '0;
        end
        dggc_pkg::CMD_SEARCH: begin
          k_q <= k_q + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // item and result registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      dggc_pkg::CMD_LOAD: begin
        item_q      <= item_i;
        limit_q     <= lim;
        status_q    <= oor ? dggc_pkg::STATUS_RANGE : dggc_pkg::STATUS_OK;
        recolored_q <= 1'b0;
        color_a_q   <= '0;
        color_b_q   <= '0;
      end
      dggc_pkg::CMD_WR_B: begin
        row_q <= row_mod;
      end
      dggc_pkg::CMD_CAP_CA: begin
        color_a_q <= col_rdata;
      end
      dggc_pkg::CMD_CAP_CB: begin
        color_b_q <= col_rdata;
        used_q    <= '0;
      end
      dggc_pkg::CMD_SCAN, dggc_pkg::CMD_DRAIN: begin
        if (hit_q) begin
          used_q[col_rdata] <= 1'b1;
        end
      end
      dggc_pkg::CMD_SEARCH: begin
        if (found) begin
          color_b_q   <= found_color;
          recolored_q <= 1'b1;
          if (item_q.vertex_a == item_q.vertex_b) begin
            color_a_q <= found_color;
          end
        end else if (none) begin
          status_q <= dggc_pkg::STATUS_NO_COLOR;
        end
      end
      default: begin
      end
    endcase
  end

  assign status_o.cnt_last     = (cnt_q == CNT_LAST);
  assign status_o.out_of_range = (status_q == dggc_pkg::STATUS_RANGE);
  assign status_o.conflict     = (item_q.kind == dggc_pkg::KIND_INSERT) &&
                                 (color_a_q == col_rdata);
  assign status_o.search_found = found;
  assign status_o.search_none  = none;

  assign result_o.color_a   = color_a_q;
  assign result_o.color_b   = color_b_q;
  assign result_o.recolored = recolored_q;
  assign result_o.status    = status_q;

endmodule

[hdl/dynamic_greedy_graph_coloring.sv]
// top level of the dynamic greedy graph colouring block
`timescale 1ns / 1ps

// sequence: an item is checked, then both adjacency rows are updated and both colours read;
//   out-of-range items go straight to the result; an insert whose endpoints share a colour
//   adds a neighbour scan with one colour ram read per slot, then a search of eight colours a cycle
// throughput: one item at a time, a new input transfer in the cycle after the result is queued
// reset: a clearing pass zeroes both rams; no input is taken meanwhile, configuration writes
//   are taken at any time; vertex_count resets to 64
module dynamic_greedy_graph_coloring #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // item channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dggc_pkg::item_t   in_data_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dggc_pkg::result_t out_data_o,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [dggc_pkg::CNT_W-1:0] vertex_count_q, vertex_count_d;
  logic                       cfg_wr;
  logic                       reg_sel;

  logic                       out_valid_q, out_valid_d;
  dggc_pkg::result_t          out_data_q;
  logic                       out_free;
  logic                       out_push;

  dggc_pkg::cmd_e             cmd;
  dggc_pkg::dp_status_t       dp_status;
  dggc_pkg::result_t          dp_result;

  // register file: a single word holding the vertex count
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'(dggc_pkg::REG_VERTEX_COUNT));
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? {{(32 - dggc_pkg::CNT_W){1'b0}}, vertex_count_q} : '0;

  assign vertex_count_d = cfg_wr ? pwdata[dggc_pkg::CNT_W-1:0] : vertex_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= dggc_pkg::COUNT_RESET;
    end else begin
      vertex_count_q <= vertex_count_d;
    end
  end

  // output register, so a waiting result never blocks the next input transfer
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_d = out_push ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_data_q <= dp_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // sequencer
  dggc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .out_push_o (out_push),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  // stores, neighbour scan and colour search
  dggc_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .item_i         (in_data_i),
    .vertex_count_i (vertex_count_q),
    .status_o       (dp_status),
    .result_o       (dp_result)
  );

endmodule
